>>> hw/rtl/tcsm_pkg.sv
package tcsm_pkg;

   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned FLAGS_W = 8;
   localparam int unsigned CTL_W   = 2;
   localparam int unsigned EV_W    = 3;

   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_LOAD    = 1'b1;

   localparam int unsigned FLAG_FIN = 0;
   localparam int unsigned FLAG_SYN = 1;
   localparam int unsigned FLAG_RST = 2;
   localparam int unsigned FLAG_ACK = 4;

   localparam logic [CODE_W-1:0] CODE_CLOSED     = 4'd0;
   localparam logic [CODE_W-1:0] CODE_LISTEN     = 4'd1;
   localparam logic [CODE_W-1:0] CODE_SYN_RECV   = 4'd2;
   localparam logic [CODE_W-1:0] CODE_SYN_SENT   = 4'd3;
   localparam logic [CODE_W-1:0] CODE_ESTAB      = 4'd4;
   localparam logic [CODE_W-1:0] CODE_CLOSE_WAIT = 4'd5;
   localparam logic [CODE_W-1:0] CODE_LAST_ACK   = 4'd6;
   localparam logic [CODE_W-1:0] CODE_FW1        = 4'd7;
   localparam logic [CODE_W-1:0] CODE_FW2        = 4'd8;
   localparam logic [CODE_W-1:0] CODE_CLOSING    = 4'd9;
   localparam logic [CODE_W-1:0] CODE_TIME_WAIT  = 4'd10;

   localparam logic [CTL_W-1:0] CTL_NONE   = 2'd0;
   localparam logic [CTL_W-1:0] CTL_ACK    = 2'd1;
   localparam logic [CTL_W-1:0] CTL_SYNACK = 2'd2;
   localparam logic [CTL_W-1:0] CTL_RST    = 2'd3;

   localparam logic [EV_W-1:0] EV_NONE      = 3'd0;
   localparam logic [EV_W-1:0] EV_INVALID   = 3'd1;
   localparam logic [EV_W-1:0] EV_RESET     = 3'd2;
   localparam logic [EV_W-1:0] EV_SPAWN     = 3'd3;
   localparam logic [EV_W-1:0] EV_ACCEPTED  = 3'd4;
   localparam logic [EV_W-1:0] EV_CONNECTED = 3'd5;
   localparam logic [EV_W-1:0] EV_TIMEWAIT  = 3'd6;
   localparam logic [EV_W-1:0] EV_CLOSED    = 3'd7;

   typedef enum logic [10:0] {
      ST_CLOSED     = 11'b000_0000_0001,
      ST_LISTEN     = 11'b000_0000_0010,
      ST_SYN_RECV   = 11'b000_0000_0100,
      ST_SYN_SENT   = 11'b000_0000_1000,
      ST_ESTAB      = 11'b000_0001_0000,
      ST_CLOSE_WAIT = 11'b000_0010_0000,
      ST_LAST_ACK   = 11'b000_0100_0000,
      ST_FW1        = 11'b000_1000_0000,
      ST_FW2        = 11'b001_0000_0000,
      ST_CLOSING    = 11'b010_0000_0000,
      ST_TIME_WAIT  = 11'b100_0000_0000
   } conn_state_type;

   typedef struct packed {
      logic               kind;
      logic [FLAGS_W-1:0] seg_flags;
      logic [SEQ_W-1:0]   seg_seq;
      logic [SEQ_W-1:0]   seg_seq_end;
      logic [SEQ_W-1:0]   seg_ack;
      logic [CODE_W-1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] new_state;
      logic [CTL_W-1:0]  send_ctl;
      logic [EV_W-1:0]   event_res;
      logic [SEQ_W-1:0]  next_receive;
      logic [SEQ_W-1:0]  next_send;
      logic [SEQ_W-1:0]  child_receive;
   } rsp_type;

   typedef struct packed {
      conn_state_type   state;
      logic [SEQ_W-1:0] rcv_next;
      logic [SEQ_W-1:0] snd_next;
   } conn_type;

   function automatic logic [CODE_W-1:0] state_to_code(input conn_state_type st);
      logic [CODE_W-1:0] code;
      case (st)
         ST_CLOSED:     code = CODE_CLOSED;
         ST_LISTEN:     code = CODE_LISTEN;
         ST_SYN_RECV:   code = CODE_SYN_RECV;
         ST_SYN_SENT:   code = CODE_SYN_SENT;
         ST_ESTAB:      code = CODE_ESTAB;
         ST_CLOSE_WAIT: code = CODE_CLOSE_WAIT;
         ST_LAST_ACK:   code = CODE_LAST_ACK;
         ST_FW1:        code = CODE_FW1;
         ST_FW2:        code = CODE_FW2;
         ST_CLOSING:    code = CODE_CLOSING;
         ST_TIME_WAIT:  code = CODE_TIME_WAIT;
         default:       code = CODE_CLOSED;
      endcase
      return code;
   endfunction

   // out-of-range codes keep the current state
   function automatic conn_state_type code_to_state(input logic [CODE_W-1:0] code,
                                                    input conn_state_type cur);
      conn_state_type st;
      case (code)
         CODE_CLOSED:     st = ST_CLOSED;
         CODE_LISTEN:     st = ST_LISTEN;
         CODE_SYN_RECV:   st = ST_SYN_RECV;
         CODE_SYN_SENT:   st = ST_SYN_SENT;
         CODE_ESTAB:      st = ST_ESTAB;
         CODE_CLOSE_WAIT: st = ST_CLOSE_WAIT;
         CODE_LAST_ACK:   st = ST_LAST_ACK;
         CODE_FW1:        st = ST_FW1;
         CODE_FW2:        st = ST_FW2;
         CODE_CLOSING:    st = ST_CLOSING;
         CODE_TIME_WAIT:  st = ST_TIME_WAIT;
         default:         st = cur;
      endcase
      return st;
   endfunction

endpackage

>>> hw/rtl/tcp_connection_state_machine.sv
// TCP connection state machine for a single connection.
// Request channel (req_valid/req_ready/req_data): kind 0 carries an incoming
// segment header (flags, seq, seq_end, ack); kind 1 loads the connection
// state from a socket call or timer. Response channel (rsp_valid/rsp_ready/
// rsp_data) returns one response per request, in order: new state, control
// segment to send, event code, rcv_nxt, snd_nxt and the child's rcv_nxt.
// An accepted request is held in the input register, which feeds the decision
// logic; that logic loads the response register when it advances, and the
// connection state and sequence registers update together with it.
// Throughput is one request per cycle while rsp_ready is high.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; req_ready drops once both are full.
// Reset clears both valid flags and puts the connection in CLOSED with
// rcv_nxt and snd_nxt at zero.
module tcp_connection_state_machine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcsm_pkg::rsp_type rsp_data
);

   logic               stage_valid;
   tcsm_pkg::req_type  stage_data;
   logic               advance;
   logic               fire;
   tcsm_pkg::conn_type conn_ff;
   tcsm_pkg::conn_type conn_in;
   tcsm_pkg::rsp_type  rsp_ff;
   tcsm_pkg::rsp_type  rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign fire         = stage_valid && advance;
   assign rsp_valid_in = advance ? stage_valid : rsp_valid_ff;

   tcsm_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   tcsm_decide u_decide (
      .req (stage_data),
      .cur (conn_ff),
      .nxt (conn_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff.state    <= tcsm_pkg::ST_CLOSED;
         conn_ff.rcv_next <= '0;
         conn_ff.snd_next <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            conn_ff <= conn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/tcsm_in_stage.sv
module tcsm_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcsm_pkg::req_type req_data,
   input  logic             advance,
   output logic             stage_valid,
   output tcsm_pkg::req_type stage_data
);

   logic              valid_ff;
   logic              valid_in;
   tcsm_pkg::req_type data_ff;

   assign req_ready   = !valid_ff || advance;
   assign valid_in    = req_ready ? req_valid : valid_ff;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

>>> hw/rtl/tcsm_decide.sv
module tcsm_decide (
   input  tcsm_pkg::req_type  req,
   input  tcsm_pkg::conn_type cur,
   output tcsm_pkg::conn_type nxt,
   output tcsm_pkg::rsp_type  rsp
);

   logic                             fin;
   logic                             syn;
   logic                             rst;
   logic                             ack;
   logic [tcsm_pkg::SEQ_W-1:0]       seq_plus1;
   logic [tcsm_pkg::CTL_W-1:0]       ctl;
   logic [tcsm_pkg::EV_W-1:0]        ev;
   logic [tcsm_pkg::SEQ_W-1:0]       child;

   assign fin       = req.seg_flags[tcsm_pkg::FLAG_FIN];
   assign syn       = req.seg_flags[tcsm_pkg::FLAG_SYN];
   assign rst       = req.seg_flags[tcsm_pkg::FLAG_RST];
   assign ack       = req.seg_flags[tcsm_pkg::FLAG_ACK];
   assign seq_plus1 = req.seg_seq + tcsm_pkg::SEQ_W'(1);

   always_comb begin
      nxt   = cur;
      ctl   = tcsm_pkg::CTL_NONE;
      ev    = tcsm_pkg::EV_NONE;
      child = '0;
      if (req.kind == tcsm_pkg::KIND_LOAD) begin
         nxt.state = tcsm_pkg::code_to_state(req.load_value, cur.state);
      end else if (rst) begin
         nxt.state = tcsm_pkg::ST_CLOSED;
         ev        = tcsm_pkg::EV_RESET;
      end else begin
         ev = tcsm_pkg::EV_INVALID;
         case (cur.state)
            tcsm_pkg::ST_CLOSED: begin
               ctl = tcsm_pkg::CTL_RST;
               ev  = tcsm_pkg::EV_NONE;
            end
            tcsm_pkg::ST_LISTEN: begin
               if (syn) begin
                  ctl   = tcsm_pkg::CTL_SYNACK;
                  ev    = tcsm_pkg::EV_SPAWN;
                  child = seq_plus1;
               end
            end
            tcsm_pkg::ST_SYN_RECV: begin
               if (ack) begin
                  nxt.state = tcsm_pkg::ST_ESTAB;
                  ev        = tcsm_pkg::EV_ACCEPTED;
               end
            end
            tcsm_pkg::ST_SYN_SENT: begin
               if (syn && ack) begin
                  nxt.rcv_next = seq_plus1;
                  nxt.snd_next = req.seg_ack;
                  nxt.state    = tcsm_pkg::ST_ESTAB;
                  ctl          = tcsm_pkg::CTL_ACK;
                  ev           = tcsm_pkg::EV_CONNECTED;
               end else if (syn) begin
                  nxt.state = tcsm_pkg::ST_SYN_RECV;
                  ctl       = tcsm_pkg::CTL_SYNACK;
                  ev        = tcsm_pkg::EV_NONE;
               end
            end
            tcsm_pkg::ST_ESTAB: begin
               if (fin) begin
                  nxt.rcv_next = req.seg_seq_end;
                  nxt.state    = tcsm_pkg::ST_CLOSE_WAIT;
                  ctl          = tcsm_pkg::CTL_ACK;
                  ev           = tcsm_pkg::EV_NONE;
               end
            end
            tcsm_pkg::ST_LAST_ACK: begin
               if (ack) begin
                  nxt.state = tcsm_pkg::ST_CLOSED;
                  ev        = tcsm_pkg::EV_CLOSED;
               end
            end
            tcsm_pkg::ST_FW1: begin
               if (ack) begin
                  nxt.state = tcsm_pkg::ST_FW2;
                  ev        = tcsm_pkg::EV_NONE;
               end else if (fin) begin
                  nxt.state = tcsm_pkg::ST_CLOSING;
                  ctl       = tcsm_pkg::CTL_ACK;
                  ev        = tcsm_pkg::EV_NONE;
               end
            end
            tcsm_pkg::ST_FW2: begin
               if (fin) begin
                  nxt.rcv_next = req.seg_seq_end;
                  nxt.state    = tcsm_pkg::ST_TIME_WAIT;
                  ctl          = tcsm_pkg::CTL_ACK;
                  ev           = tcsm_pkg::EV_TIMEWAIT;
               end
            end
            tcsm_pkg::ST_CLOSING: begin
               if (ack) begin
                  nxt.state = tcsm_pkg::ST_TIME_WAIT;
                  ev        = tcsm_pkg::EV_TIMEWAIT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp.new_state     = tcsm_pkg::state_to_code(nxt.state);
      rsp.send_ctl      = ctl;
      rsp.event_res     = ev;
      rsp.next_receive  = nxt.rcv_next;
      rsp.next_send     = nxt.snd_next;
      rsp.child_receive = child;
   end

endmodule

>>> tb/sv/conn_response_checker.sv
module conn_response_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tcsm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tcsm_pkg::rsp_type rsp_data,
   output int                failures,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tcsm_pkg::*;

   logic [CODE_W-1:0] conn_code;
   logic [SEQ_W-1:0]  rcv_nxt;
   logic [SEQ_W-1:0]  snd_nxt;
   rsp_type           expected_rsp[$];

   initial begin
      failures      = 0;
      pending_count = 0;
   end

   // advances the connection by one request and returns the response it must produce
   function automatic rsp_type apply_request(input req_type r);
      rsp_type rsp;
      logic    fin_set;
      logic    syn_set;
      logic    ack_set;
      rsp     = '0;
      fin_set = r.seg_flags[FLAG_FIN];
      syn_set = r.seg_flags[FLAG_SYN];
      ack_set = r.seg_flags[FLAG_ACK];
      rsp.send_ctl  = CTL_NONE;
      rsp.event_res = EV_NONE;
      if (r.kind == KIND_LOAD) begin
         if (r.load_value <= CODE_TIME_WAIT) begin
            conn_code = r.load_value;
         end
      end else if (r.seg_flags[FLAG_RST]) begin
         conn_code     = CODE_CLOSED;
         rsp.event_res = EV_RESET;
      end else begin
         rsp.event_res = EV_INVALID;
         case (conn_code)
            CODE_CLOSED: begin
               rsp.send_ctl  = CTL_RST;
               rsp.event_res = EV_NONE;
            end
            CODE_LISTEN: begin
               if (syn_set) begin
                  rsp.send_ctl      = CTL_SYNACK;
                  rsp.event_res     = EV_SPAWN;
                  rsp.child_receive = r.seg_seq + 32'd1;
               end
            end
            CODE_SYN_RECV: begin
               if (ack_set) begin
                  conn_code     = CODE_ESTAB;
                  rsp.event_res = EV_ACCEPTED;
               end
            end
            CODE_SYN_SENT: begin
               if (syn_set && ack_set) begin
                  rcv_nxt       = r.seg_seq + 32'd1;
                  snd_nxt       = r.seg_ack;
                  rsp.send_ctl  = CTL_ACK;
                  conn_code     = CODE_ESTAB;
                  rsp.event_res = EV_CONNECTED;
               end else if (syn_set) begin
                  rsp.send_ctl  = CTL_SYNACK;
                  conn_code     = CODE_SYN_RECV;
                  rsp.event_res = EV_NONE;
               end
            end
            CODE_ESTAB: begin
               if (fin_set) begin
                  rcv_nxt       = r.seg_seq_end;
                  rsp.send_ctl  = CTL_ACK;
                  conn_code     = CODE_CLOSE_WAIT;
                  rsp.event_res = EV_NONE;
               end
            end
            CODE_LAST_ACK: begin
               if (ack_set) begin
                  conn_code     = CODE_CLOSED;
                  rsp.event_res = EV_CLOSED;
               end
            end
            CODE_FW1: begin
               if (ack_set) begin
                  conn_code     = CODE_FW2;
                  rsp.event_res = EV_NONE;
               end else if (fin_set) begin
                  rsp.send_ctl  = CTL_ACK;
                  conn_code     = CODE_CLOSING;
                  rsp.event_res = EV_NONE;
               end
            end
            CODE_FW2: begin
               if (fin_set) begin
                  rcv_nxt       = r.seg_seq_end;
                  rsp.send_ctl  = CTL_ACK;
                  conn_code     = CODE_TIME_WAIT;
                  rsp.event_res = EV_TIMEWAIT;
               end
            end
            CODE_CLOSING: begin
               if (ack_set) begin
                  conn_code     = CODE_TIME_WAIT;
                  rsp.event_res = EV_TIMEWAIT;
               end
            end
            default: begin
            end
         endcase
      end
      rsp.new_state    = conn_code;
      rsp.next_receive = rcv_nxt;
      rsp.next_send    = snd_nxt;
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         conn_code = CODE_CLOSED;
         rcv_nxt   = '0;
         snd_nxt   = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               failures++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("new_state", want.new_state, rsp_data.new_state);
               check_field("send_ctl", want.send_ctl, rsp_data.send_ctl);
               check_field("event_res", want.event_res, rsp_data.event_res);
               check_field("next_receive", want.next_receive, rsp_data.next_receive);
               check_field("next_send", want.next_send, rsp_data.next_send);
               check_field("child_receive", want.child_receive, rsp_data.child_receive);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp.push_back(apply_request(req_data));
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

>>> tb/sv/tcp_connection_state_machine_test.sv
module tcp_connection_state_machine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tcsm_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int TOTAL_REQS   = 1925;
   localparam int PHASE_LENGTH = 300;

   localparam logic [FLAGS_W-1:0] FIN_BIT = FLAGS_W'(1 << FLAG_FIN);
   localparam logic [FLAGS_W-1:0] SYN_BIT = FLAGS_W'(1 << FLAG_SYN);
   localparam logic [FLAGS_W-1:0] RST_BIT = FLAGS_W'(1 << FLAG_RST);
   localparam logic [FLAGS_W-1:0] ACK_BIT = FLAGS_W'(1 << FLAG_ACK);
   localparam logic [FLAGS_W-1:0] SPARE_BITS = 8'hE8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int failures;
   int pending_count;
   int sent_count = 0;
   int send_gap_pct = 20;
   int rsp_stall_pct = 20;
   int stall_left = 0;
   int quiet_cycles = 0;

   tcp_connection_state_machine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   conn_response_checker response_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .failures      (failures),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_length(rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type seg_fields(input logic [FLAGS_W-1:0] flags,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [SEQ_W-1:0] seq_end,
                                          input logic [SEQ_W-1:0] ack);
      req_type r;
      r.kind        = KIND_SEGMENT;
      r.seg_flags   = flags;
      r.seg_seq     = seq;
      r.seg_seq_end = seq_end;
      r.seg_ack     = ack;
      r.load_value  = CODE_W'($urandom);
      return r;
   endfunction

   function automatic logic [FLAGS_W-1:0] pad_flags(input logic [FLAGS_W-1:0] base);
      return base | (FLAGS_W'($urandom) & SPARE_BITS);
   endfunction

   // random numbers, now and then right at the wrap point
   function automatic req_type rand_seg(input logic [FLAGS_W-1:0] flags);
      logic [SEQ_W-1:0] seq;
      seq = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
      return seg_fields(flags, seq, seq + $urandom_range(1, 1500), $urandom);
   endfunction

   function automatic req_type load_req(input logic [CODE_W-1:0] code);
      req_type r;
      r.kind        = KIND_LOAD;
      r.seg_flags   = FLAGS_W'($urandom);
      r.seg_seq     = $urandom;
      r.seg_seq_end = $urandom;
      r.seg_ack     = $urandom;
      r.load_value  = code;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = idle_length(send_gap_pct);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [FLAGS_W-1:0] fl;
      int                 next_phase_at;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_request(seg_fields(8'h00, 32'h0, 32'h0, 32'h0));
      send_request(seg_fields(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(load_req(CODE_LISTEN));
      send_request(seg_fields(SYN_BIT, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678));
      send_request(seg_fields(ACK_BIT, 32'h1, 32'h2, 32'h3));
      send_request(load_req(CODE_SYN_SENT));
      send_request(seg_fields(SYN_BIT, 32'h8000_0000, 32'h8000_0001, 32'h0));
      send_request(seg_fields(ACK_BIT | SPARE_BITS, 32'h0, 32'h0, 32'h0));
      send_request(load_req(CODE_SYN_SENT));
      send_request(seg_fields(SYN_BIT | ACK_BIT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
      send_request(seg_fields(ACK_BIT, 32'h10, 32'h20, 32'h30));
      send_request(seg_fields(FIN_BIT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0));
      send_request(seg_fields(FIN_BIT | SYN_BIT | ACK_BIT, 32'h5, 32'h6, 32'h7));
      send_request(load_req(CODE_LAST_ACK));
      send_request(seg_fields(ACK_BIT, 32'h0, 32'h0, 32'h0));
      send_request(load_req(CODE_FW1));
      send_request(seg_fields(FIN_BIT | ACK_BIT, 32'h100, 32'h101, 32'h0));
      send_request(seg_fields(FIN_BIT, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0));
      send_request(seg_fields(SYN_BIT | ACK_BIT, 32'h0, 32'h0, 32'h0));
      send_request(load_req(CODE_FW1));
      send_request(seg_fields(FIN_BIT, 32'h0, 32'h1, 32'h0));
      send_request(seg_fields(ACK_BIT, 32'h0, 32'h0, 32'h0));
      send_request(load_req(4'd15));
      send_request(load_req(CODE_CLOSED));

      wait_for_responses();
      next_phase_at = sent_count;
      while (sent_count < TOTAL_REQS) begin
         if (sent_count >= next_phase_at) begin
            wait_for_responses();
            case ($urandom_range(0, 3))
               0: begin
                  send_gap_pct  = 0;
                  rsp_stall_pct = 0;
               end
               1: begin
                  send_gap_pct  = 30;
                  rsp_stall_pct = 30;
               end
               2: begin
                  send_gap_pct  = 10;
                  rsp_stall_pct = 60;
               end
               default: begin
                  send_gap_pct  = 60;
                  rsp_stall_pct = 10;
               end
            endcase
            next_phase_at = sent_count + PHASE_LENGTH;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // passive open, then remote close
               send_request(load_req(CODE_LISTEN));
               repeat ($urandom_range(1, 3)) send_request(rand_seg(pad_flags(SYN_BIT)));
               send_request(load_req(CODE_SYN_RECV));
               send_request(rand_seg(pad_flags(ACK_BIT)));
               repeat ($urandom_range(0, 2)) send_request(rand_seg(pad_flags(ACK_BIT)));
               send_request(rand_seg(pad_flags(FIN_BIT | ACK_BIT)));
               send_request(load_req(CODE_LAST_ACK));
               send_request(rand_seg(pad_flags(ACK_BIT)));
            end
            3, 4, 5: begin
               // active open, then local close
               send_request(load_req(CODE_SYN_SENT));
               if ($urandom_range(0, 2) != 0) begin
                  send_request(rand_seg(pad_flags(SYN_BIT | ACK_BIT)));
               end else begin
                  send_request(rand_seg(pad_flags(SYN_BIT)));
                  send_request(rand_seg(pad_flags(ACK_BIT)));
               end
               send_request(load_req(CODE_FW1));
               if ($urandom_range(0, 1) != 0) begin
                  send_request(rand_seg(pad_flags(ACK_BIT)));
                  send_request(rand_seg(pad_flags(FIN_BIT | (ACK_BIT & 8'($urandom)))));
               end else begin
                  send_request(rand_seg(pad_flags(FIN_BIT)));
                  send_request(rand_seg(pad_flags(ACK_BIT)));
               end
               send_request(rand_seg(pad_flags(FLAGS_W'($urandom) & ~RST_BIT)));
               send_request(load_req(CODE_CLOSED));
            end
            6, 7, 8: begin
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     send_request(load_req(CODE_W'($urandom_range(0, 15))));
                  end else begin
                     fl = FLAGS_W'($urandom);
                     if ($urandom_range(0, 3) != 0) begin
                        fl[FLAG_RST] = 1'b0;
                     end
                     send_request(rand_seg(fl));
                  end
               end
            end
            default: begin
               // reset segment in the middle of a connection
               send_request(load_req(CODE_W'($urandom_range(0, 10))));
               if ($urandom_range(0, 1) != 0) begin
                  send_request(rand_seg(pad_flags(FLAGS_W'($urandom) & ~RST_BIT)));
               end
               send_request(rand_seg(FLAGS_W'($urandom) | RST_BIT));
            end
         endcase
      end

      wait_for_responses();
      repeat (10) @(posedge clock);
      if (failures == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
